>>> design/ugb_pkg.sv
`timescale 1ns / 1ps
package ugb_pkg;

  localparam int MAX_COLS     = 32;
  localparam int MAX_ROWS     = 32;
  localparam int BUCKET_DEPTH = 16;
  localparam int COL_W        = $clog2(MAX_COLS);
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int CELL_W       = COL_W + ROW_W;
  localparam int NCELLS       = MAX_COLS * MAX_ROWS;
  localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
  localparam int FILL_W       = SLOT_W + 1;
  localparam int ID_W         = 10;
  localparam int POS_W        = 16;
  localparam int CS_W         = 13;
  localparam int GRID_W       = 6;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;
  localparam int DIV_CNT_W    = $clog2(POS_W);

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_ID   = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ID_W-1:0]  object_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] neighbour_id;
    logic [1:0]      status;
    logic            last;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] qx;
    logic [POS_W-1:0] qy;
  } div_rsp_t;

endpackage

>>> design/ugb_ram.sv
`timescale 1ns / 1ps
module ugb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/ugb_div.sv
`timescale 1ns / 1ps
module ugb_div (
  input  logic               clk,
  input  logic               rst,
  input  ugb_pkg::div_req_t  req,
  output ugb_pkg::div_rsp_t  rsp
);
  import ugb_pkg::*;

  // two restoring dividers sharing one divisor, one quotient bit per cycle
  logic                     busy;
  logic [DIV_CNT_W-1:0]     cnt;
  logic [CS_W-1:0]          d;
  logic [CS_W-1:0]          rx, ry;
  logic [POS_W-1:0]         qx, qy;
  logic [CS_W:0]            tx, ty;
  logic                     gx, gy;
  logic                     done;

  always_comb begin
    tx = {rx, qx[POS_W-1]};
    ty = {ry, qy[POS_W-1]};
    gx = tx >= {1'b0, d};
    gy = ty >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        d    <= (req.divisor == '0) ? CS_W'(1) : req.divisor;
        rx   <= '0;
        ry   <= '0;
        qx   <= req.x;
        qy   <= req.y;
      end else if (busy) begin
        rx  <= gx ? CS_W'(tx - {1'b0, d}) : tx[CS_W-1:0];
        ry  <= gy ? CS_W'(ty - {1'b0, d}) : ty[CS_W-1:0];
        qx  <= {qx[POS_W-2:0], gx};
        qy  <= {qy[POS_W-2:0], gy};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.qx   = qx;
  assign rsp.qy   = qy;
endmodule

>>> design/uniform_grid_broadphase.sv
`timescale 1ns / 1ps
// Uniform grid collision broadphase.
// Input channel (in_valid/in_ready/in_data) takes one word per operation:
// register an object id in its cell, clear the grid, or query the ids in the
// object's cell and its east, south-east and south neighbours.
// Output channel (out_valid/out_ready/out_data) returns an acknowledge for
// register and clear, and for a query one word per id found (last set on the
// final one) or a single "none" word.
// Configuration (cell_size, grid_cols, grid_rows) sits on an APB port at
// byte addresses 0, 4 and 8; pready is always high.
// Cell coordinates come from a serial divider. Clear sweeps the 1024-entry
// fill memory one entry a cycle; reset runs the same sweep, and no word is
// taken until it ends.
// One operation is in flight at a time. A finished word waits in the output
// register while the next operation is accepted; the block stalls only when
// it has a new word and the receiver has not taken the previous one.
module uniform_grid_broadphase (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ugb_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ugb_pkg::out_word_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ugb_pkg::PADDR_W-1:0]   paddr,
  input  logic [ugb_pkg::PDATA_W-1:0]   pwdata,
  output logic [ugb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ugb_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_CHK, S_REG, S_FRD, S_SEL, S_IDW, S_OUT
  } state_t;

  state_t state, ret;

  // config registers
  logic [CS_W-1:0]   cell_size;
  logic [GRID_W-1:0] grid_cols, grid_rows;
  logic [GRID_W-1:0] cols_u, rows_u;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CS_W'(32);
      grid_cols <= GRID_W'(32);
      grid_rows <= GRID_W'(32);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CELL_SIZE: cell_size <= pwdata[CS_W-1:0];
        REG_GRID_COLS: grid_cols <= pwdata[GRID_W-1:0];
        REG_GRID_ROWS: grid_rows <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_SIZE: prdata = PDATA_W'(cell_size);
      REG_GRID_COLS: prdata = PDATA_W'(grid_cols);
      REG_GRID_ROWS: prdata = PDATA_W'(grid_rows);
      default:       prdata = '0;
    endcase
  end

  assign cols_u = (grid_cols > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : grid_cols;
  assign rows_u = (grid_rows > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : grid_rows;

  // operation registers
  logic [1:0]        op;
  logic [ID_W-1:0]   oid;
  logic [POS_W-1:0]  cx, cy;
  logic              in_grid;
  logic [CELL_W-1:0] clr_cnt;
  logic              clr_ack;
  logic [2:0]        phase;
  logic [1:0]        cur_c;
  logic [FILL_W-1:0] slot;
  logic [FILL_W-1:0] fills [4];
  out_word_t         res;
  logic              in_acc;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign div_req.start   = in_acc &&
                           (in_data.opcode == OP_REGISTER || in_data.opcode == OP_QUERY);
  assign div_req.x       = in_data.pos_x;
  assign div_req.y       = in_data.pos_y;
  assign div_req.divisor = cell_size;

  ugb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_grid = (cx < POS_W'(cols_u)) && (cy < POS_W'(rows_u));

  // the four scanned cells: own, east, south-east, south
  logic [CELL_W-1:0] c_addr [4];
  logic              c_ok   [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [COL_W:0] nx;
      logic [ROW_W:0] ny;
      nx = {1'b0, cx[COL_W-1:0]} + ((k == 1 || k == 2) ? (COL_W+1)'(1) : '0);
      ny = {1'b0, cy[ROW_W-1:0]} + ((k == 2 || k == 3) ? (ROW_W+1)'(1) : '0);
      c_ok[k]   = (GRID_W'(nx) < cols_u) && (GRID_W'(ny) < rows_u);
      c_addr[k] = {ny[ROW_W-1:0], nx[COL_W-1:0]};
    end
  end

  // memories
  logic                     fill_we;
  logic [CELL_W-1:0]        fill_waddr, fill_raddr;
  logic [FILL_W-1:0]        fill_wdata, fill_rdata;
  logic                     ids_we;
  logic [CELL_W+SLOT_W-1:0] ids_waddr, ids_raddr;
  logic [ID_W-1:0]          ids_rdata;
  logic                     full;
  logic                     later_nz;
  logic                     id_last;

  assign full = fill_rdata >= FILL_W'(BUCKET_DEPTH);

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = c_addr[0];
    fill_wdata = fill_rdata + 1'b1;
    fill_raddr = c_addr[0];
    ids_we     = 1'b0;
    ids_waddr  = {c_addr[0], fill_rdata[SLOT_W-1:0]};
    ids_raddr  = {c_addr[cur_c], slot[SLOT_W-1:0]};
    case (state)
      S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_cnt;
        fill_wdata = '0;
      end
      S_REG: begin
        fill_we = !full;
        ids_we  = !full;
      end
      S_FRD: fill_raddr = c_addr[phase[1:0]];
      default: ;
    endcase
  end

  ugb_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  ugb_ram #(.WIDTH(ID_W), .DEPTH(NCELLS * BUCKET_DEPTH)) u_ids (
    .clk   (clk),
    .we    (ids_we),
    .waddr (ids_waddr),
    .wdata (oid),
    .raddr (ids_raddr),
    .rdata (ids_rdata)
  );

  // last id: end of this bucket and nothing in the later cells
  always_comb begin
    later_nz = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (k > int'(cur_c) && fills[k] != '0) later_nz = 1'b1;
    end
    id_last = ((slot + 1'b1) == fills[cur_c]) && !later_nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_IDLE;
      clr_cnt   <= '0;
      clr_ack   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_OUT reloads the register itself when the word is taken
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CELL_W'(NCELLS - 1)) begin
            if (clr_ack) begin
              res   <= '{kind: KIND_ACK, neighbour_id: '0, status: ST_OK, last: 1'b1};
              ret   <= S_IDLE;
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op  <= in_data.opcode;
            oid <= in_data.object_id;
            case (in_data.opcode)
              OP_REGISTER, OP_QUERY: state <= S_DIV;
              OP_CLEAR: begin
                clr_cnt <= '0;
                clr_ack <= 1'b1;
                state   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cx    <= div_rsp.qx;
            cy    <= div_rsp.qy;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          phase <= '0;
          if (!in_grid) begin
            res <= '{kind: (op == OP_QUERY) ? KIND_NONE : KIND_ACK,
                     neighbour_id: '0, status: ST_OUTSIDE, last: 1'b1};
            ret   <= S_IDLE;
            state <= S_OUT;
          end else if (op == OP_QUERY) begin
            state <= S_FRD;
          end else begin
            state <= S_REG;
          end
        end
        S_REG: begin
          res <= '{kind: KIND_ACK, neighbour_id: '0,
                   status: full ? ST_FULL : ST_OK, last: 1'b1};
          ret   <= S_IDLE;
          state <= S_OUT;
        end
        S_FRD: begin
          phase <= phase + 1'b1;
          if (phase != '0) begin
            fills[2'(phase - 1'b1)] <= c_ok[2'(phase - 1'b1)] ? fill_rdata : '0;
          end
          if (phase == 3'd4) begin
            cur_c <= '0;
            slot  <= '0;
            if ((fills[0] | fills[1] | fills[2]) == '0 &&
                !(c_ok[3] && fill_rdata != '0)) begin
              res   <= '{kind: KIND_NONE, neighbour_id: '0, status: ST_OK, last: 1'b1};
              ret   <= S_IDLE;
              state <= S_OUT;
            end else begin
              state <= S_SEL;
            end
          end
        end
        S_SEL: begin
          if (slot < fills[cur_c]) begin
            state <= S_IDW;
          end else begin
            cur_c <= cur_c + 1'b1;
            slot  <= '0;
          end
        end
        S_IDW: begin
          res   <= '{kind: KIND_ID, neighbour_id: ids_rdata, status: ST_OK, last: id_last};
          slot  <= slot + 1'b1;
          ret   <= id_last ? S_IDLE : S_SEL;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            clr_ack   <= 1'b0;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a bucket never grows past its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_wdata <= FILL_W'(BUCKET_DEPTH))
    else $error("bucket fill beyond depth");

  // a valid operation closes the input until its words are out
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.opcode != OP_UNUSED) |=> !in_ready)
    else $error("input taken while busy");

  // a new output word only comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output word without source");
`endif
endmodule
